// ----- hw/rtl/path_normalizer_defines.svh -----
// Assertion macros for the path normalizer.
// Included by the top level; expects clk and rst_n in scope.
`ifndef PATH_NORMALIZER_DEFINES_SVH
`define PATH_NORMALIZER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PN_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("path_normalizer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("path_normalizer: next-cycle check failed");

`endif

// ----- hw/rtl/pn_pkg.sv -----
// Shared types and constants for the path normalizer.
// Used by the controller, the datapath and the top level; no dependencies.
package pn_pkg;

    localparam logic [7:0] SLASH = 8'h2F;
    localparam logic [7:0] DOT   = 8'h2E;

    typedef logic [1:0] wr_sel_t;

    localparam wr_sel_t WR_DOT   = 2'd0;
    localparam wr_sel_t WR_SLASH = 2'd1;
    localparam wr_sel_t WR_CH    = 2'd2;
    localparam wr_sel_t WR_NONE  = 2'd3;

    typedef struct packed {
        logic    take_ch;
        logic    clear;
        logic    cnt_inc;
        logic    set_ovf;
        logic    set_started;
        logic    set_abs;
        logic    pd_inc;
        logic    pd_clr;
        logic    acs_set;
        logic    acs_clr;
        logic    depth_inc;
        logic    depth_dec;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    scan_load;
        logic    scan_dec;
        logic    scan_rd;
        logic    rp_rd;
        logic    wp_from_scan;
        logic    trim;
        logic    set_done;
        logic    out_load;
    } pn_cmd_t;

    typedef struct packed {
        logic       started;
        logic       ch_slash;
        logic       ch_dot;
        logic       acs;
        logic [1:0] pd;
        logic       depth_zero;
        logic       abs;
        logic       done;
        logic       in_full;
        logic       wp_zero;
        logic       wp_gt1;
        logic       tail_slash;
        logic       scan_zero;
        logic       rd_slash;
        logic       out_busy;
    } pn_status_t;

endpackage

// ----- hw/rtl/pn_in_if.sv -----
// Input channel of the path normalizer: handshake plus one command item.
// No dependencies.
interface pn_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] ch;
    logic       last;
    logic       has_input_char;

    modport source (output valid, output op, output ch, output last,
                    output has_input_char, input ready);
    modport sink (input valid, input op, input ch, input last,
                  input has_input_char, output ready);
endinterface

// ----- hw/rtl/pn_out_if.sv -----
// Output channel of the path normalizer: handshake plus one result item.
// No dependencies.
interface pn_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       char_valid;
    logic       out_last;
    logic       overflow;

    modport source (output valid, output out_char, output char_valid,
                    output out_last, output overflow, input ready);
    modport sink (input valid, input out_char, input char_valid,
                  input out_last, input overflow, output ready);
endinterface

// ----- hw/rtl/path_normalizer.sv -----
// Top level of the streaming POSIX path normalizer.
// Depends on pn_pkg, pn_in_if, pn_out_if, pn_ctrl, pn_datapath and the defines header.
//
//   Port   Direction  Carries
//   cmd    sink       op, ch, last, has_input_char
//   rsp    source     out_char, char_valid, out_last, overflow
//
// A path byte is handled in the feed state; the first byte of a name and its held dots,
// the three dots of "...", and a relative "../" are then written byte by byte in the
// emit state. A ".." that removes a component scans the buffer back to the previous slash.
// Closing a path runs the trim and final-dot states; a read goes through the buffer port.
// Reset is asynchronous; the result buffer is not cleared and needs no sweep.
// A read waits while the output register holds an untaken transfer.
`include "path_normalizer_defines.svh"

module path_normalizer #(
    parameter int MAX_LEN = 256
) (
    input logic      clk,
    input logic      rst_n,
    pn_in_if.sink    cmd,
    pn_out_if.source rsp
);

    pn_pkg::pn_cmd_t    dp_cmd;
    pn_pkg::pn_status_t dp_status;
    logic               ctl_ready;

    assign cmd.ready = ctl_ready;

    pn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_op    (cmd.op),
        .in_last  (cmd.last),
        .in_has   (cmd.has_input_char),
        .in_ready (ctl_ready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    pn_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .ch     (cmd.ch),
        .cmd    (dp_cmd),
        .status (dp_status),
        .rsp    (rsp)
    );

    `PN_ASSERT_NEXT(a_read_holds_input, cmd.valid && ctl_ready && cmd.op, !ctl_ready)
    `PN_ASSERT_SAME(a_no_result_overwrite, dp_cmd.out_load, !(rsp.valid && !rsp.ready))
    `PN_ASSERT_SAME(a_empty_char_zero, rsp.valid && !rsp.char_valid, rsp.out_char == 8'h00)

endmodule

// ----- hw/rtl/pn_datapath.sv -----
// Datapath of the path normalizer: path state, result buffer and output register.
// Depends on pn_pkg and pn_out_if; driven by pn_ctrl through pn_cmd_t.
module pn_datapath #(
    parameter int MAX_LEN = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         ch,
    input  pn_pkg::pn_cmd_t    cmd,
    output pn_pkg::pn_status_t status,
    pn_out_if.source           rsp
);

    localparam int BUF_LEN = MAX_LEN + 1;
    localparam int AW      = $clog2(BUF_LEN);
    localparam int PTR_W   = $clog2(BUF_LEN + 1);
    localparam int CNT_W   = $clog2(MAX_LEN + 1);

    logic [7:0] mem [BUF_LEN];
    logic [7:0] rd_data_reg;
    logic [7:0] ch_reg;

    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [PTR_W-1:0] depth_reg, depth_next;
    logic [PTR_W-1:0] scan_reg, scan_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       pd_reg, pd_next;
    logic abs_reg, abs_next;
    logic started_reg, started_next;
    logic acs_reg, acs_next;
    logic done_reg, done_next;
    logic ovf_reg, ovf_next;
    logic tail_reg, tail_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg;
    logic       char_valid_reg;
    logic       out_last_reg;
    logic       out_ovf_reg;

    logic [7:0]       wr_byte;
    logic             wp_lt_buf;
    logic             rp_lt_wp;
    logic [PTR_W-1:0] scan_m1;
    logic [AW-1:0]    rd_addr;
    logic [PTR_W-1:0] rp_p1;

    assign wp_lt_buf = wp_reg < PTR_W'(BUF_LEN);
    assign rp_lt_wp  = rp_reg < wp_reg;
    assign scan_m1   = scan_reg - PTR_W'(1);
    assign rp_p1     = rp_reg + PTR_W'(1);
    assign rd_addr   = cmd.scan_rd ? scan_m1[AW-1:0] : rp_reg[AW-1:0];

    always_comb
    begin
        case (cmd.wr_sel)
            pn_pkg::WR_DOT:   wr_byte = pn_pkg::DOT;
            pn_pkg::WR_SLASH: wr_byte = pn_pkg::SLASH;
            pn_pkg::WR_CH:    wr_byte = ch_reg;
            default:          wr_byte = ch_reg;
        endcase
    end

    always_comb
    begin
        wp_next      = wp_reg;
        rp_next      = rp_reg;
        depth_next   = depth_reg;
        scan_next    = scan_reg;
        cnt_next     = cnt_reg;
        pd_next      = pd_reg;
        abs_next     = abs_reg;
        started_next = started_reg;
        acs_next     = acs_reg;
        done_next    = done_reg;
        ovf_next     = ovf_reg;
        tail_next    = tail_reg;
        if (cmd.clear)
        begin
            wp_next      = '0;
            rp_next      = '0;
            depth_next   = '0;
            cnt_next     = '0;
            pd_next      = '0;
            abs_next     = 1'b0;
            started_next = 1'b0;
            acs_next     = 1'b1;
            done_next    = 1'b0;
            ovf_next     = 1'b0;
        end
        else
        begin
            if (cmd.cnt_inc)
                cnt_next = cnt_reg + CNT_W'(1);
            if (cmd.set_ovf)
                ovf_next = 1'b1;
            if (cmd.set_started)
                started_next = 1'b1;
            if (cmd.set_abs)
                abs_next = 1'b1;
            if (cmd.pd_inc)
                pd_next = pd_reg + 2'd1;
            if (cmd.pd_clr)
                pd_next = '0;
            if (cmd.acs_set)
                acs_next = 1'b1;
            if (cmd.acs_clr)
                acs_next = 1'b0;
            if (cmd.depth_inc)
                depth_next = depth_reg + PTR_W'(1);
            if (cmd.depth_dec)
                depth_next = depth_reg - PTR_W'(1);
            if (cmd.wr_en)
            begin
                if (wp_lt_buf)
                begin
                    wp_next   = wp_reg + PTR_W'(1);
                    tail_next = (wr_byte == pn_pkg::SLASH);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            if (cmd.scan_load)
                scan_next = (wp_reg == '0) ? '0 : wp_reg - PTR_W'(1);
            if (cmd.scan_dec)
                scan_next = scan_m1;
            if (cmd.wp_from_scan)
            begin
                wp_next   = scan_reg;
                tail_next = (scan_reg != '0);
            end
            if (cmd.trim)
                wp_next = wp_reg - PTR_W'(1);
            if (cmd.set_done)
                done_next = 1'b1;
            if (cmd.out_load && done_reg && rp_lt_wp)
                rp_next = rp_p1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            rp_reg        <= '0;
            depth_reg     <= '0;
            scan_reg      <= '0;
            cnt_reg       <= '0;
            pd_reg        <= '0;
            abs_reg       <= 1'b0;
            started_reg   <= 1'b0;
            acs_reg       <= 1'b1;
            done_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            tail_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            depth_reg     <= depth_next;
            scan_reg      <= scan_next;
            cnt_reg       <= cnt_next;
            pd_reg        <= pd_next;
            abs_reg       <= abs_next;
            started_reg   <= started_next;
            acs_reg       <= acs_next;
            done_reg      <= done_next;
            ovf_reg       <= ovf_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_ch)
            ch_reg <= ch;
        if (cmd.wr_en && wp_lt_buf)
            mem[wp_reg[AW-1:0]] <= wr_byte;
        if (cmd.scan_rd || cmd.rp_rd)
            rd_data_reg <= mem[rd_addr];
        if (cmd.out_load)
        begin
            out_ovf_reg <= ovf_reg;
            if (done_reg && rp_lt_wp)
            begin
                out_char_reg   <= rd_data_reg;
                char_valid_reg <= 1'b1;
                out_last_reg   <= (rp_p1 == wp_reg);
            end
            else
            begin
                out_char_reg   <= 8'h00;
                char_valid_reg <= 1'b0;
                out_last_reg   <= done_reg;
            end
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.out_char   = out_char_reg;
    assign rsp.char_valid = char_valid_reg;
    assign rsp.out_last   = out_last_reg;
    assign rsp.overflow   = out_ovf_reg;

    assign status.started    = started_reg;
    assign status.ch_slash   = (ch_reg == pn_pkg::SLASH);
    assign status.ch_dot     = (ch_reg == pn_pkg::DOT);
    assign status.acs        = acs_reg;
    assign status.pd         = pd_reg;
    assign status.depth_zero = (depth_reg == '0);
    assign status.abs        = abs_reg;
    assign status.done       = done_reg;
    assign status.in_full    = (cnt_reg == CNT_W'(MAX_LEN));
    assign status.wp_zero    = (wp_reg == '0);
    assign status.wp_gt1     = (wp_reg > PTR_W'(1));
    assign status.tail_slash = tail_reg;
    assign status.scan_zero  = (scan_reg == '0);
    assign status.rd_slash   = (rd_data_reg == pn_pkg::SLASH);
    assign status.out_busy   = out_valid_reg && !rsp.ready;

endmodule

// ----- hw/rtl/pn_ctrl.sv -----
// Controller of the path normalizer: sequences each command item over the datapath.
// Depends on pn_pkg; drives pn_datapath through pn_cmd_t.
module pn_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_op,
    input  logic               in_last,
    input  logic               in_has,
    output logic               in_ready,
    input  pn_pkg::pn_status_t status,
    output pn_pkg::pn_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_FEED     = 4'd1;
    localparam logic [3:0] S_FIN      = 4'd2;
    localparam logic [3:0] S_UP       = 4'd3;
    localparam logic [3:0] S_SCAN_CHK = 4'd4;
    localparam logic [3:0] S_SCAN_CMP = 4'd5;
    localparam logic [3:0] S_EMIT     = 4'd6;
    localparam logic [3:0] S_TRIM     = 4'd7;
    localparam logic [3:0] S_FDOT     = 4'd8;
    localparam logic [3:0] S_READ_REQ = 4'd9;
    localparam logic [3:0] S_READ_OUT = 4'd10;

    logic [3:0]      state_reg, state_next;
    logic [3:0]      ret_reg, ret_next;
    logic [1:0]      dots_reg, dots_next;
    pn_pkg::wr_sel_t kind_reg, kind_next;
    logic            last_reg, last_next;
    logic [3:0]      after_feed;

    assign in_ready   = (state_reg == S_IDLE);
    assign after_feed = last_reg ? S_FIN : S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        dots_next  = dots_reg;
        kind_next  = kind_reg;
        last_next  = last_reg;
        cmd        = '0;
        cmd.wr_sel = pn_pkg::WR_CH;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_ch = 1'b1;
                    last_next   = in_last;
                    if (in_op)
                    begin
                        state_next = S_READ_REQ;
                    end
                    else if (in_has || in_last)
                    begin
                        cmd.clear  = status.done;
                        state_next = in_has ? S_FEED : S_FIN;
                    end
                end
            end
            S_FEED:
            begin
                state_next = after_feed;
                ret_next   = after_feed;
                if (status.in_full)
                begin
                    cmd.set_ovf = 1'b1;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                    if (!status.started)
                        cmd.set_started = 1'b1;
                    if (!status.started && status.ch_slash)
                    begin
                        cmd.set_abs = 1'b1;
                        cmd.wr_en   = 1'b1;
                        cmd.wr_sel  = pn_pkg::WR_SLASH;
                    end
                    else if (status.ch_slash && status.acs)
                    begin
                        cmd.pd_clr = 1'b1;
                        if (status.pd == 2'd2)
                            state_next = S_UP;
                    end
                    else if (status.ch_slash)
                    begin
                        cmd.wr_en     = 1'b1;
                        cmd.wr_sel    = pn_pkg::WR_SLASH;
                        cmd.depth_inc = 1'b1;
                        cmd.acs_set   = 1'b1;
                    end
                    else if (status.ch_dot && status.acs)
                    begin
                        if (status.pd != 2'd2)
                        begin
                            cmd.pd_inc = 1'b1;
                        end
                        else
                        begin
                            cmd.pd_clr  = 1'b1;
                            cmd.acs_clr = 1'b1;
                            dots_next   = 2'd3;
                            kind_next   = pn_pkg::WR_NONE;
                            state_next  = S_EMIT;
                        end
                    end
                    else if (status.acs)
                    begin
                        cmd.pd_clr  = 1'b1;
                        cmd.acs_clr = 1'b1;
                        dots_next   = status.pd;
                        kind_next   = pn_pkg::WR_CH;
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_sel = pn_pkg::WR_CH;
                    end
                end
            end
            S_FIN:
            begin
                cmd.pd_clr = 1'b1;
                ret_next   = S_TRIM;
                state_next = (status.pd == 2'd2) ? S_UP : S_TRIM;
            end
            S_UP:
            begin
                if (!status.depth_zero)
                begin
                    cmd.scan_load = 1'b1;
                    state_next    = S_SCAN_CHK;
                end
                else if (!status.abs)
                begin
                    dots_next  = 2'd2;
                    kind_next  = pn_pkg::WR_SLASH;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = ret_reg;
                end
            end
            S_SCAN_CHK:
            begin
                if (status.scan_zero)
                begin
                    cmd.wp_from_scan = 1'b1;
                    cmd.depth_dec    = 1'b1;
                    state_next       = ret_reg;
                end
                else
                begin
                    cmd.scan_rd = 1'b1;
                    state_next  = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                if (status.rd_slash)
                begin
                    cmd.wp_from_scan = 1'b1;
                    cmd.depth_dec    = 1'b1;
                    state_next       = ret_reg;
                end
                else
                begin
                    cmd.scan_dec = 1'b1;
                    state_next   = S_SCAN_CHK;
                end
            end
            S_EMIT:
            begin
                if (dots_reg != 2'd0)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = pn_pkg::WR_DOT;
                    dots_next  = dots_reg - 2'd1;
                    if (dots_reg == 2'd1 && kind_reg == pn_pkg::WR_NONE)
                        state_next = ret_reg;
                end
                else if (kind_reg != pn_pkg::WR_NONE)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = kind_reg;
                    kind_next  = pn_pkg::WR_NONE;
                    state_next = ret_reg;
                end
                else
                begin
                    state_next = ret_reg;
                end
            end
            S_TRIM:
            begin
                cmd.trim   = status.wp_gt1 && status.tail_slash;
                state_next = S_FDOT;
            end
            S_FDOT:
            begin
                cmd.wr_en    = status.wp_zero;
                cmd.wr_sel   = pn_pkg::WR_DOT;
                cmd.set_done = 1'b1;
                state_next   = S_IDLE;
            end
            S_READ_REQ:
            begin
                cmd.rp_rd  = 1'b1;
                state_next = S_READ_OUT;
            end
            S_READ_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            dots_reg  <= '0;
            kind_reg  <= pn_pkg::WR_NONE;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            dots_reg  <= dots_next;
            kind_reg  <= kind_next;
            last_reg  <= last_next;
        end
    end

endmodule

// ----- verif/path_normalizer_test.sv -----
// Self-checking testbench for path_normalizer: a directed table, then random paths.
// Depends on pn_pkg, pn_in_if, pn_out_if and the path_normalizer RTL.
// Results are checked against a built-in model of the normalization rules, or pinned table values.
module path_normalizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN = 256;
    localparam int BUF_LEN = MAX_LEN + 1;
    localparam int ITEM_TARGET = 1300;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_CYCLES = 40;

    localparam bit [7:0] SLASH = pn_pkg::SLASH;
    localparam bit [7:0] DOT = pn_pkg::DOT;

    localparam bit OP_FEED = 1'b0;
    localparam bit OP_READ = 1'b1;

    typedef struct packed {
        bit [7:0] out_char;
        bit       char_valid;
        bit       out_last;
        bit       overflow;
    } norm_char_t;

    typedef struct packed {
        bit         op;
        bit [7:0]   ch;
        bit         last;
        bit         has;
        bit         pinned;
        norm_char_t want;
    } cmd_row_t;

    localparam norm_char_t NO_CHAR  = '{8'h00, 1'b0, 1'b0, 1'b0};
    localparam norm_char_t PAST_END = '{8'h00, 1'b0, 1'b1, 1'b0};
    localparam norm_char_t LONE_DOT = '{DOT, 1'b1, 1'b1, 1'b0};

    localparam cmd_row_t DIRECTED [29] = '{
        '{OP_READ, 8'h00, 1'b0, 1'b0, 1'b1, NO_CHAR},
        '{OP_FEED, 8'h00, 1'b1, 1'b0, 1'b0, NO_CHAR},
        '{OP_READ, 8'h00, 1'b0, 1'b0, 1'b1, LONE_DOT},
        '{OP_READ, 8'hFF, 1'b1, 1'b1, 1'b1, PAST_END},
        '{OP_FEED, DOT,   1'b0, 1'b1, 1'b0, NO_CHAR},
        '{OP_FEED, DOT,   1'b0, 1'b1, 1'b0, NO_CHAR},
        '{OP_FEED, SLASH, 1'b0, 1'b1, 1'b0, NO_CHAR},
        '{OP_FEED, 8'hA5, 1'b0, 1'b0, 1'b0, NO_CHAR},
        '{OP_READ, 8'h00, 1'b0, 1'b0, 1'b1, NO_CHAR},
        '{OP_FEED, DOT,   1'b0, 1'b1, 1'b0, NO_CHAR},
        '{OP_FEED, DOT,   1'b1, 1'b1, 1'b0, NO_CHAR},
        '{OP_READ, 8'h00, 1'b0, 1'b0, 1'b0, NO_CHAR},
        '{OP_READ, 8'h00, 1'b0, 1'b0, 1'b0, NO_CHAR},
        '{OP_FEED, SLASH, 1'b0, 1'b1, 1'b0, NO_CHAR},
        '{OP_FEED, SLASH, 1'b0, 1'b1, 1'b0, NO_CHAR},
        '{OP_FEED, 8'h00, 1'b0, 1'b1, 1'b0, NO_CHAR},
        '{OP_FEED, SLASH, 1'b0, 1'b1, 1'b0, NO_CHAR},
        '{OP_FEED, DOT,   1'b0, 1'b1, 1'b0, NO_CHAR},
        '{OP_FEED, DOT,   1'b0, 1'b1, 1'b0, NO_CHAR},
        '{OP_FEED, DOT,   1'b0, 1'b1, 1'b0, NO_CHAR},
        '{OP_FEED, 8'hFF, 1'b1, 1'b1, 1'b0, NO_CHAR},
        '{OP_READ, 8'h00, 1'b0, 1'b0, 1'b0, NO_CHAR},
        '{OP_READ, 8'hFF, 1'b1, 1'b1, 1'b0, NO_CHAR},
        '{OP_READ, 8'h00, 1'b0, 1'b0, 1'b0, NO_CHAR},
        '{OP_READ, 8'h00, 1'b0, 1'b0, 1'b0, NO_CHAR},
        '{OP_READ, 8'h00, 1'b0, 1'b0, 1'b0, NO_CHAR},
        '{OP_READ, 8'h00, 1'b0, 1'b0, 1'b0, NO_CHAR},
        '{OP_READ, 8'h00, 1'b0, 1'b0, 1'b0, NO_CHAR},
        '{OP_READ, 8'h00, 1'b0, 1'b0, 1'b0, NO_CHAR}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pn_in_if  cmd_if ();
    pn_out_if rsp_if ();

    path_normalizer #(.MAX_LEN(MAX_LEN)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    always #6 clk = ~clk;

    // Normalizer model state.
    bit [7:0] path_buf [BUF_LEN];
    bit [8:0] wr_idx;
    bit [8:0] rd_idx;
    bit [7:0] removable;
    bit       rooted;
    bit [1:0] dot_run;
    bit       comp_open;
    bit       closed;
    bit       truncated;
    bit       seen_byte;
    bit [8:0] byte_count;

    norm_char_t want_q [$];
    bit [7:0]   path_q [$];

    int mismatches = 0;
    int live_items = 0;
    int sent_total = 0;
    int taken_total = 0;
    int cycle_count = 0;
    bit send_burst = 1'b0;
    bit take_burst = 1'b0;

    function automatic void restart_path();
        wr_idx = '0;
        rd_idx = '0;
        removable = '0;
        rooted = 1'b0;
        dot_run = '0;
        comp_open = 1'b1;
        closed = 1'b0;
        truncated = 1'b0;
        seen_byte = 1'b0;
        byte_count = '0;
    endfunction

    function automatic void put_char(input bit [7:0] c);
        if (wr_idx < BUF_LEN)
        begin
            path_buf[wr_idx] = c;
            wr_idx++;
        end
        else
            truncated = 1'b1;
    endfunction

    function automatic void settle_dots();
        int p;
        if (dot_run == 2'd2)
        begin
            if (removable > 0)
            begin
                p = (wr_idx > 0) ? int'(wr_idx) - 1 : 0;
                while (p > 0 && path_buf[p - 1] != SLASH)
                    p--;
                wr_idx = 9'(p);
                removable--;
            end
            else if (!rooted)
            begin
                put_char(DOT);
                put_char(DOT);
                put_char(SLASH);
            end
        end
        dot_run = '0;
    endfunction

    function automatic bit normalize_step(input bit op, input bit [7:0] c, input bit lst,
                                          input bit has, output norm_char_t r);
        r = NO_CHAR;
        if (op == OP_FEED)
        begin
            if (!has && !lst)
                return 1'b0;
            if (closed)
                restart_path();
            if (has && byte_count >= MAX_LEN)
                truncated = 1'b1;
            else if (has)
            begin
                byte_count++;
                if (!seen_byte && c == SLASH)
                begin
                    seen_byte = 1'b1;
                    rooted = 1'b1;
                    put_char(SLASH);
                end
                else
                begin
                    seen_byte = 1'b1;
                    if (c == SLASH)
                    begin
                        if (comp_open)
                            settle_dots();
                        else
                        begin
                            put_char(SLASH);
                            removable++;
                            comp_open = 1'b1;
                        end
                    end
                    else if (c == DOT && comp_open)
                    begin
                        if (dot_run < 2'd2)
                            dot_run++;
                        else
                        begin
                            put_char(DOT);
                            put_char(DOT);
                            put_char(DOT);
                            dot_run = '0;
                            comp_open = 1'b0;
                        end
                    end
                    else
                    begin
                        if (comp_open)
                        begin
                            repeat (dot_run)
                                put_char(DOT);
                            dot_run = '0;
                            comp_open = 1'b0;
                        end
                        put_char(c);
                    end
                end
            end
            if (lst)
            begin
                if (comp_open)
                    settle_dots();
                if (wr_idx > 1 && path_buf[wr_idx - 1] == SLASH)
                    wr_idx--;
                if (wr_idx == 0)
                    put_char(DOT);
                closed = 1'b1;
            end
            return 1'b0;
        end
        r.overflow = truncated;
        if (!closed)
            return 1'b1;
        if (rd_idx < wr_idx && rd_idx < BUF_LEN)
        begin
            r.out_char = path_buf[rd_idx];
            r.char_valid = 1'b1;
            r.out_last = (int'(rd_idx) + 1 >= int'(wr_idx));
            rd_idx++;
        end
        else
            r.out_last = 1'b1;
        return 1'b1;
    endfunction

    function automatic bit [7:0] noise_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return SLASH;
        if (r < 7)
            return DOT;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic bit [7:0] name_byte();
        bit [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == SLASH)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    task automatic send_cmd(input bit op, input bit [7:0] c, input bit lst, input bit has,
                            input bit pinned, input norm_char_t pinned_val);
        int gap;
        norm_char_t r;
        if (sent_total % 50 == 0)
            send_burst = ($urandom_range(0, 3) == 0);
        sent_total++;
        gap = send_burst ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_if.valid <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
        @(negedge clk);
        cmd_if.valid <= 1'b1;
        cmd_if.op <= op;
        cmd_if.ch <= c;
        cmd_if.last <= lst;
        cmd_if.has_input_char <= has;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        if (normalize_step(op, c, lst, has, r))
            want_q.push_back(pinned ? pinned_val : r);
        if (op == OP_READ || has || lst)
            live_items++;
    endtask

    task automatic send_read();
        send_cmd(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 1'b0, NO_CHAR);
    endtask

    task automatic drain_results();
        @(negedge clk);
        cmd_if.valid <= 1'b0;
        while (want_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic log_mismatch(input string what, input norm_char_t w);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected char=%02h valid=%b last=%b ovf=%b, got char=%02h %s%b %s%b %s%b",
                     what, w.out_char, w.char_valid, w.out_last, w.overflow,
                     rsp_if.out_char, "valid=", rsp_if.char_valid, "last=", rsp_if.out_last,
                     "ovf=", rsp_if.overflow);
    endtask

    always @(posedge clk)
    begin
        norm_char_t w;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (want_q.size() == 0)
                log_mismatch("unexpected transfer", NO_CHAR);
            else
            begin
                w = want_q.pop_front();
                if (rsp_if.out_char !== w.out_char || rsp_if.char_valid !== w.char_valid ||
                    rsp_if.out_last !== w.out_last || rsp_if.overflow !== w.overflow)
                    log_mismatch("mismatch", w);
            end
        end
    end

    initial
    begin
        int stall;
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (taken_total % 40 == 0)
                take_burst = ($urandom_range(0, 3) == 0);
            taken_total++;
            stall = take_burst ? 0 : $urandom_range(0, 17);
            if (stall > 0)
            begin
                @(negedge clk);
                rsp_if.ready <= 1'b0;
                repeat (stall - 1)
                    @(negedge clk);
            end
            @(negedge clk);
            rsp_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_if.valid && rsp_if.ready));
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int path_no;
        int ncomp;
        int reads;
        int sel;
        bit last_on_byte;

        cmd_if.valid = 1'b0;
        cmd_if.op = OP_FEED;
        cmd_if.ch = 8'h00;
        cmd_if.last = 1'b0;
        cmd_if.has_input_char = 1'b0;
        foreach (path_buf[i])
            path_buf[i] = 8'h00;
        restart_path();

        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < $size(DIRECTED); i++)
            send_cmd(DIRECTED[i].op, DIRECTED[i].ch, DIRECTED[i].last, DIRECTED[i].has,
                     DIRECTED[i].pinned, DIRECTED[i].want);

        path_no = 0;
        while (live_items < ITEM_TARGET)
        begin
            if (path_no == 2 || $urandom_range(0, 7) == 0)
                drain_results();
            path_q.delete();
            if (path_no == 3)
            begin
                repeat (MAX_LEN)
                    path_q.push_back(noise_byte());
            end
            else if (path_no == 7)
            begin
                repeat ($urandom_range(MAX_LEN + 1, MAX_LEN + 6))
                    path_q.push_back(noise_byte());
            end
            else if (path_no == 11)
            begin
                // Relative parent runs that nearly fill the buffer.
                repeat (84)
                begin
                    path_q.push_back(DOT);
                    path_q.push_back(DOT);
                    path_q.push_back(SLASH);
                end
                path_q.push_back(DOT);
                path_q.push_back(DOT);
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(0, 24))
                    path_q.push_back(noise_byte());
            end
            else
            begin
                if ($urandom_range(0, 1))
                    path_q.push_back(SLASH);
                ncomp = $urandom_range(0, 6);
                for (int k = 0; k < ncomp; k++)
                begin
                    case ($urandom_range(0, 7))
                        0: ;
                        1: path_q.push_back(DOT);
                        2:
                        begin
                            path_q.push_back(DOT);
                            path_q.push_back(DOT);
                        end
                        3:
                        begin
                            repeat ($urandom_range(3, 4))
                                path_q.push_back(DOT);
                        end
                        4:
                        begin
                            repeat ($urandom_range(1, 2))
                                path_q.push_back(DOT);
                            path_q.push_back(name_byte());
                        end
                        default:
                        begin
                            repeat ($urandom_range(1, 5))
                                path_q.push_back(name_byte());
                        end
                    endcase
                    if (k < ncomp - 1 || $urandom_range(0, 2) == 0)
                    begin
                        repeat ($urandom_range(1, 3))
                            path_q.push_back(SLASH);
                    end
                end
            end

            last_on_byte = (path_q.size() > 0) && ($urandom_range(0, 1) == 1);
            foreach (path_q[i])
            begin
                if ($urandom_range(0, 19) == 0)
                    send_cmd(OP_FEED, 8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, NO_CHAR);
                if ($urandom_range(0, 29) == 0)
                    send_read();
                send_cmd(OP_FEED, path_q[i], last_on_byte && (i == path_q.size() - 1), 1'b1,
                         1'b0, NO_CHAR);
            end
            if (!last_on_byte)
                send_cmd(OP_FEED, 8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0, NO_CHAR);

            sel = $urandom_range(0, 19);
            if (sel < 12)
                reads = int'(wr_idx) + $urandom_range(0, 2);
            else if (sel < 17)
                reads = $urandom_range(0, wr_idx);
            else
                reads = 0;
            repeat (reads)
                send_read();
            path_no++;
        end

        drain_results();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
